[rtl/c8ie_pkg.sv]
// Shared types, opcode names and helper functions for the 8-bit instruction execute block.
// It depends on nothing else. The execute datapath and the top level both use it.
package c8ie_pkg;

  localparam int MEM_ADDR_BITS_DEF = 16;

  localparam logic [15:0] IO_PAGE = 16'hFF00;

  localparam logic [2:0] REG_B = 3'd0;
  localparam logic [2:0] REG_C = 3'd1;
  localparam logic [2:0] REG_D = 3'd2;
  localparam logic [2:0] REG_E = 3'd3;
  localparam logic [2:0] REG_H = 3'd4;
  localparam logic [2:0] REG_L = 3'd5;
  localparam logic [2:0] REG_M = 3'd6;
  localparam logic [2:0] REG_A = 3'd7;

  localparam logic [1:0] PAIR_BC = 2'd0;
  localparam logic [1:0] PAIR_DE = 2'd1;
  localparam logic [1:0] PAIR_HL = 2'd2;
  localparam logic [1:0] PAIR_SP = 2'd3;

  localparam logic [2:0] ALU_ADD = 3'd0;
  localparam logic [2:0] ALU_ADC = 3'd1;
  localparam logic [2:0] ALU_SUB = 3'd2;
  localparam logic [2:0] ALU_SBC = 3'd3;
  localparam logic [2:0] ALU_AND = 3'd4;
  localparam logic [2:0] ALU_XOR = 3'd5;
  localparam logic [2:0] ALU_OR  = 3'd6;
  localparam logic [2:0] ALU_CP  = 3'd7;

  localparam logic [7:0] OP_LD_BC_A  = 8'h02;
  localparam logic [7:0] OP_LD_DE_A  = 8'h12;
  localparam logic [7:0] OP_LDI_HL_A = 8'h22;
  localparam logic [7:0] OP_LDD_HL_A = 8'h32;
  localparam logic [7:0] OP_LD_A_BC  = 8'h0A;
  localparam logic [7:0] OP_LD_A_DE  = 8'h1A;
  localparam logic [7:0] OP_LDI_A_HL = 8'h2A;
  localparam logic [7:0] OP_RLCA     = 8'h07;
  localparam logic [7:0] OP_RRCA     = 8'h0F;
  localparam logic [7:0] OP_RLA      = 8'h17;
  localparam logic [7:0] OP_RRA      = 8'h1F;
  localparam logic [7:0] OP_LD_NN_SP = 8'h08;
  localparam logic [7:0] OP_STOP     = 8'h10;
  localparam logic [7:0] OP_JR       = 8'h18;
  localparam logic [7:0] OP_DAA      = 8'h27;
  localparam logic [7:0] OP_CPL      = 8'h2F;
  localparam logic [7:0] OP_SCF      = 8'h37;
  localparam logic [7:0] OP_CCF      = 8'h3F;
  localparam logic [7:0] OP_HALT     = 8'h76;
  localparam logic [7:0] OP_JP       = 8'hC3;
  localparam logic [7:0] OP_RET      = 8'hC9;
  localparam logic [7:0] OP_CALL     = 8'hCD;
  localparam logic [7:0] OP_LDH_N_A  = 8'hE0;
  localparam logic [7:0] OP_LDH_A_N  = 8'hF0;
  localparam logic [7:0] OP_LDH_C_A  = 8'hE2;
  localparam logic [7:0] OP_LDH_A_C  = 8'hF2;
  localparam logic [7:0] OP_LD_NN_A  = 8'hEA;
  localparam logic [7:0] OP_LD_A_NN  = 8'hFA;
  localparam logic [7:0] OP_ADD_SP   = 8'hE8;
  localparam logic [7:0] OP_JP_HL    = 8'hE9;
  localparam logic [7:0] OP_DI       = 8'hF3;
  localparam logic [7:0] OP_EI       = 8'hFB;

  // Flags are packed as Z, N, H, C from the top bit down.
  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  a;
    logic [3:0]  f;
    logic [15:0] bc;
    logic [15:0] de;
    logic [15:0] hl;
    logic [15:0] sp;
    logic        ime;
  } regs_t;

  typedef struct packed {
    logic        rd;
    logic        wr;
    logic [15:0] addr;
    logic [7:0]  data;
  } acc_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] addr;
    logic [7:0]  data;
  } store_t;

  typedef struct packed {
    logic [7:0] a;
    logic [3:0] f;
  } alu_res_t;

  function automatic acc_t acc_wr(logic [15:0] addr, logic [7:0] data);
    acc_t r;
    r.rd = 1'b0;
    r.wr = 1'b1;
    r.addr = addr;
    r.data = data;
    return r;
  endfunction

  function automatic acc_t acc_rd(logic [15:0] addr);
    acc_t r;
    r.rd = 1'b1;
    r.wr = 1'b0;
    r.addr = addr;
    r.data = 8'h00;
    return r;
  endfunction

  function automatic logic [7:0] get8(regs_t r, logic [2:0] s, logic [7:0] m);
    logic [7:0] v;
    case (s)
      REG_B: v = r.bc[15:8];
      REG_C: v = r.bc[7:0];
      REG_D: v = r.de[15:8];
      REG_E: v = r.de[7:0];
      REG_H: v = r.hl[15:8];
      REG_L: v = r.hl[7:0];
      REG_M: v = m;
      default: v = r.a;
    endcase
    return v;
  endfunction

  function automatic regs_t set8(regs_t r, logic [2:0] s, logic [7:0] v);
    regs_t n;
    n = r;
    case (s)
      REG_B: n.bc[15:8] = v;
      REG_C: n.bc[7:0] = v;
      REG_D: n.de[15:8] = v;
      REG_E: n.de[7:0] = v;
      REG_H: n.hl[15:8] = v;
      REG_L: n.hl[7:0] = v;
      REG_A: n.a = v;
      default: n = r;
    endcase
    return n;
  endfunction

  function automatic logic [15:0] get_pair(regs_t r, logic [1:0] p);
    logic [15:0] v;
    case (p)
      PAIR_BC: v = r.bc;
      PAIR_DE: v = r.de;
      PAIR_HL: v = r.hl;
      default: v = r.sp;
    endcase
    return v;
  endfunction

  function automatic regs_t set_pair(regs_t r, logic [1:0] p, logic [15:0] v);
    regs_t n;
    n = r;
    case (p)
      PAIR_BC: n.bc = v;
      PAIR_DE: n.de = v;
      PAIR_HL: n.hl = v;
      default: n.sp = v;
    endcase
    return n;
  endfunction

  function automatic logic cond_met(logic [3:0] f, logic [1:0] cc);
    logic b;
    b = cc[1] ? f[0] : f[3];
    return cc[0] ? b : !b;
  endfunction

  function automatic alu_res_t alu(logic [2:0] sel, logic [7:0] a, logic [3:0] f,
                                   logic [7:0] v);
    alu_res_t   res;
    logic       cin;
    logic [8:0] r9;
    logic [4:0] h5;
    logic       hf;
    logic       cf;
    cin = ((sel == ALU_ADC) || (sel == ALU_SBC)) ? f[0] : 1'b0;
    r9 = 9'd0;
    h5 = 5'd0;
    hf = 1'b0;
    cf = 1'b0;
    res.a = a;
    res.f = f;
    case (sel)
      ALU_ADD, ALU_ADC: begin
        r9 = {1'b0, a} + {1'b0, v} + {8'd0, cin};
        h5 = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
        res.f = {(r9[7:0] == 8'd0), 1'b0, h5[4], r9[8]};
        res.a = r9[7:0];
      end
      ALU_SUB, ALU_SBC, ALU_CP: begin
        r9 = {1'b0, a} - {1'b0, v} - {8'd0, cin};
        hf = {1'b0, a[3:0]} < ({1'b0, v[3:0]} + {4'd0, cin});
        cf = {1'b0, a} < ({1'b0, v} + {8'd0, cin});
        res.f = {(r9[7:0] == 8'd0), 1'b1, hf, cf};
        if (sel != ALU_CP) begin
          res.a = r9[7:0];
        end
      end
      ALU_AND: begin
        res.a = a & v;
        res.f = {((a & v) == 8'd0), 3'b010};
      end
      ALU_XOR: begin
        res.a = a ^ v;
        res.f = {((a ^ v) == 8'd0), 3'b000};
      end
      default: begin
        res.a = a | v;
        res.f = {((a | v) == 8'd0), 3'b000};
      end
    endcase
    return res;
  endfunction

endpackage

[rtl/c8ie_exec.sv]
// Instruction decode and execute datapath: memory access plan and register update.
// Purely combinational; uses types and functions from c8ie_pkg.
module c8ie_exec (
  input  logic [7:0]          op_i,
  input  logic [7:0]          lo_i,
  input  logic [7:0]          hi_i,
  input  c8ie_pkg::regs_t     regs_i,
  input  logic [15:0]         mdat_i,
  output c8ie_pkg::regs_t     regs_o,
  output logic                taken_o,
  output c8ie_pkg::acc_t      acc1_o,
  output c8ie_pkg::acc_t      acc2_o,
  output c8ie_pkg::store_t    store_o
);

  c8ie_pkg::regs_t    n;
  c8ie_pkg::acc_t     a1;
  c8ie_pkg::acc_t     a2;
  c8ie_pkg::alu_res_t alr;
  logic [15:0]        nn;
  logic [15:0]        pc1;
  logic [15:0]        sext;
  logic [15:0]        pv;
  logic [15:0]        pushv;
  logic [7:0]         srcv;
  logic [7:0]         dstv;
  logic [7:0]         incv;
  logic [7:0]         decv;
  logic [7:0]         dt;
  logic               dc;
  logic               cnd;
  logic               taken;
  logic [16:0]        s17;
  logic [12:0]        h13;
  logic [4:0]         h5;
  logic [8:0]         c9;

  always_comb begin
    nn = {hi_i, lo_i};
    pc1 = regs_i.pc + 16'd1;
    sext = {{8{lo_i[7]}}, lo_i};
    pv = c8ie_pkg::get_pair(regs_i, op_i[5:4]);
    srcv = c8ie_pkg::get8(regs_i, op_i[2:0], mdat_i[7:0]);
    dstv = c8ie_pkg::get8(regs_i, op_i[5:3], mdat_i[7:0]);
    incv = dstv + 8'd1;
    decv = dstv - 8'd1;
    cnd = c8ie_pkg::cond_met(regs_i.f, op_i[4:3]);
    alr = c8ie_pkg::alu(op_i[5:3], regs_i.a, regs_i.f,
                        (op_i[7:6] == 2'b10) ? srcv : lo_i);
    s17 = {1'b0, regs_i.hl} + {1'b0, pv};
    h13 = {1'b0, regs_i.hl[11:0]} + {1'b0, pv[11:0]};
    h5 = {1'b0, regs_i.sp[3:0]} + {1'b0, lo_i[3:0]};
    c9 = {1'b0, regs_i.sp[7:0]} + {1'b0, lo_i};
    pushv = (op_i[5:4] == c8ie_pkg::PAIR_SP) ? {regs_i.a, regs_i.f, 4'b0000} : pv;
    n = regs_i;
    n.pc = pc1;
    taken = 1'b0;
    a1 = '0;
    a2 = '0;
    dt = 8'd0;
    dc = 1'b0;

    if (op_i[7:6] == 2'b01) begin
      if (op_i != c8ie_pkg::OP_HALT) begin
        if (op_i[5:3] == c8ie_pkg::REG_M) begin
          a1 = c8ie_pkg::acc_wr(regs_i.hl, srcv);
        end else begin
          if (op_i[2:0] == c8ie_pkg::REG_M) begin
            a1 = c8ie_pkg::acc_rd(regs_i.hl);
          end
          n = c8ie_pkg::set8(n, op_i[5:3], srcv);
        end
      end
    end else if (op_i[7:6] == 2'b10) begin
      if (op_i[2:0] == c8ie_pkg::REG_M) begin
        a1 = c8ie_pkg::acc_rd(regs_i.hl);
      end
      n.a = alr.a;
      n.f = alr.f;
    end else if ((op_i & 8'hC7) == 8'h04) begin
      n.f = {(incv == 8'd0), 1'b0, (dstv[3:0] == 4'hF), regs_i.f[0]};
      if (op_i[5:3] == c8ie_pkg::REG_M) begin
        a1 = c8ie_pkg::acc_rd(regs_i.hl);
        a2 = c8ie_pkg::acc_wr(regs_i.hl, incv);
      end else begin
        n = c8ie_pkg::set8(n, op_i[5:3], incv);
      end
    end else if ((op_i & 8'hC7) == 8'h05) begin
      n.f = {(dstv == 8'd1), 1'b1, (dstv[3:0] == 4'h0), regs_i.f[0]};
      if (op_i[5:3] == c8ie_pkg::REG_M) begin
        a1 = c8ie_pkg::acc_rd(regs_i.hl);
        a2 = c8ie_pkg::acc_wr(regs_i.hl, decv);
      end else begin
        n = c8ie_pkg::set8(n, op_i[5:3], decv);
      end
    end else if ((op_i & 8'hC7) == 8'h06) begin
      if (op_i[5:3] == c8ie_pkg::REG_M) begin
        a1 = c8ie_pkg::acc_wr(regs_i.hl, lo_i);
      end else begin
        n = c8ie_pkg::set8(n, op_i[5:3], lo_i);
      end
      n.pc = regs_i.pc + 16'd2;
    end else if ((op_i & 8'hCF) == 8'h01) begin
      n = c8ie_pkg::set_pair(n, op_i[5:4], nn);
      n.pc = regs_i.pc + 16'd3;
    end else if ((op_i & 8'hCF) == 8'h03) begin
      n = c8ie_pkg::set_pair(n, op_i[5:4], pv + 16'd1);
    end else if ((op_i & 8'hCF) == 8'h0B) begin
      n = c8ie_pkg::set_pair(n, op_i[5:4], pv - 16'd1);
    end else if ((op_i & 8'hCF) == 8'h09) begin
      n.f = {regs_i.f[3], 1'b0, h13[12], s17[16]};
      n.hl = s17[15:0];
    end else if ((op_i & 8'hE7) == 8'h20) begin
      n.pc = regs_i.pc + 16'd2;
      if (cnd) begin
        n.pc = regs_i.pc + 16'd2 + sext;
        taken = 1'b1;
      end
    end else if ((op_i & 8'hE7) == 8'hC0) begin
      if (cnd) begin
        a1 = c8ie_pkg::acc_rd(regs_i.sp);
        a2 = c8ie_pkg::acc_rd(regs_i.sp + 16'd1);
        n.sp = regs_i.sp + 16'd2;
        n.pc = mdat_i;
        taken = 1'b1;
      end
    end else if ((op_i & 8'hE7) == 8'hC2) begin
      n.pc = regs_i.pc + 16'd3;
      if (cnd) begin
        n.pc = nn;
        taken = 1'b1;
      end
    end else if ((op_i & 8'hE7) == 8'hC4) begin
      n.pc = regs_i.pc + 16'd3;
      if (cnd) begin
        a1 = c8ie_pkg::acc_wr(regs_i.sp - 16'd1, n.pc[15:8]);
        a2 = c8ie_pkg::acc_wr(regs_i.sp - 16'd2, n.pc[7:0]);
        n.sp = regs_i.sp - 16'd2;
        n.pc = nn;
        taken = 1'b1;
      end
    end else if ((op_i & 8'hCF) == 8'hC1) begin
      a1 = c8ie_pkg::acc_rd(regs_i.sp);
      a2 = c8ie_pkg::acc_rd(regs_i.sp + 16'd1);
      n.sp = regs_i.sp + 16'd2;
      if (op_i[5:4] == c8ie_pkg::PAIR_SP) begin
        n.a = mdat_i[15:8];
        n.f = mdat_i[7:4];
      end else begin
        n = c8ie_pkg::set_pair(n, op_i[5:4], mdat_i);
      end
    end else if ((op_i & 8'hCF) == 8'hC5) begin
      a1 = c8ie_pkg::acc_wr(regs_i.sp - 16'd1, pushv[15:8]);
      a2 = c8ie_pkg::acc_wr(regs_i.sp - 16'd2, pushv[7:0]);
      n.sp = regs_i.sp - 16'd2;
    end else if ((op_i & 8'hC7) == 8'hC6) begin
      n.a = alr.a;
      n.f = alr.f;
      n.pc = regs_i.pc + 16'd2;
    end else if ((op_i & 8'hC7) == 8'hC7) begin
      a1 = c8ie_pkg::acc_wr(regs_i.sp - 16'd1, pc1[15:8]);
      a2 = c8ie_pkg::acc_wr(regs_i.sp - 16'd2, pc1[7:0]);
      n.sp = regs_i.sp - 16'd2;
      n.pc = {10'd0, op_i[5:3], 3'b000};
    end else begin
      case (op_i)
        c8ie_pkg::OP_LD_BC_A: a1 = c8ie_pkg::acc_wr(regs_i.bc, regs_i.a);
        c8ie_pkg::OP_LD_DE_A: a1 = c8ie_pkg::acc_wr(regs_i.de, regs_i.a);
        c8ie_pkg::OP_LDI_HL_A: begin
          a1 = c8ie_pkg::acc_wr(regs_i.hl, regs_i.a);
          n.hl = regs_i.hl + 16'd1;
        end
        c8ie_pkg::OP_LDD_HL_A: begin
          a1 = c8ie_pkg::acc_wr(regs_i.hl, regs_i.a);
          n.hl = regs_i.hl - 16'd1;
        end
        c8ie_pkg::OP_LD_A_BC: begin
          a1 = c8ie_pkg::acc_rd(regs_i.bc);
          n.a = mdat_i[7:0];
        end
        c8ie_pkg::OP_LD_A_DE: begin
          a1 = c8ie_pkg::acc_rd(regs_i.de);
          n.a = mdat_i[7:0];
        end
        c8ie_pkg::OP_LDI_A_HL: begin
          a1 = c8ie_pkg::acc_rd(regs_i.hl);
          n.a = mdat_i[7:0];
          n.hl = regs_i.hl + 16'd1;
        end
        c8ie_pkg::OP_RLCA: begin
          n.f = {3'b000, regs_i.a[7]};
          n.a = {regs_i.a[6:0], regs_i.a[7]};
        end
        c8ie_pkg::OP_RRCA: begin
          n.f = {3'b000, regs_i.a[0]};
          n.a = {regs_i.a[0], regs_i.a[7:1]};
        end
        c8ie_pkg::OP_RLA: begin
          n.f = {3'b000, regs_i.a[7]};
          n.a = {regs_i.a[6:0], regs_i.f[0]};
        end
        c8ie_pkg::OP_RRA: begin
          n.f = {3'b000, regs_i.a[0]};
          n.a = {regs_i.f[0], regs_i.a[7:1]};
        end
        c8ie_pkg::OP_LD_NN_SP: begin
          a1 = c8ie_pkg::acc_wr(nn, regs_i.sp[7:0]);
          a2 = c8ie_pkg::acc_wr(nn + 16'd1, regs_i.sp[15:8]);
          n.pc = regs_i.pc + 16'd3;
        end
        c8ie_pkg::OP_STOP: n.pc = regs_i.pc + 16'd2;
        c8ie_pkg::OP_JR: n.pc = regs_i.pc + 16'd2 + sext;
        c8ie_pkg::OP_DAA: begin
          dt = regs_i.a;
          dc = regs_i.f[0];
          if (!regs_i.f[2]) begin
            if (dc || (regs_i.a > 8'h99)) begin
              dt = dt + 8'h60;
              dc = 1'b1;
            end
            if (regs_i.f[1] || (dt[3:0] > 4'h9)) begin
              dt = dt + 8'h06;
            end
          end else begin
            if (dc) begin
              dt = dt - 8'h60;
            end
            if (regs_i.f[1]) begin
              dt = dt - 8'h06;
            end
          end
          n.a = dt;
          n.f = {(dt == 8'd0), regs_i.f[2], 1'b0, dc};
        end
        c8ie_pkg::OP_CPL: begin
          n.a = ~regs_i.a;
          n.f = {regs_i.f[3], 2'b11, regs_i.f[0]};
        end
        c8ie_pkg::OP_SCF: n.f = {regs_i.f[3], 3'b001};
        c8ie_pkg::OP_CCF: n.f = {regs_i.f[3], 2'b00, !regs_i.f[0]};
        c8ie_pkg::OP_JP: n.pc = nn;
        c8ie_pkg::OP_RET: begin
          a1 = c8ie_pkg::acc_rd(regs_i.sp);
          a2 = c8ie_pkg::acc_rd(regs_i.sp + 16'd1);
          n.sp = regs_i.sp + 16'd2;
          n.pc = mdat_i;
        end
        c8ie_pkg::OP_CALL: begin
          n.pc = regs_i.pc + 16'd3;
          a1 = c8ie_pkg::acc_wr(regs_i.sp - 16'd1, n.pc[15:8]);
          a2 = c8ie_pkg::acc_wr(regs_i.sp - 16'd2, n.pc[7:0]);
          n.sp = regs_i.sp - 16'd2;
          n.pc = nn;
        end
        c8ie_pkg::OP_LDH_N_A: begin
          a1 = c8ie_pkg::acc_wr(c8ie_pkg::IO_PAGE | {8'd0, lo_i}, regs_i.a);
          n.pc = regs_i.pc + 16'd2;
        end
        c8ie_pkg::OP_LDH_A_N: begin
          a1 = c8ie_pkg::acc_rd(c8ie_pkg::IO_PAGE | {8'd0, lo_i});
          n.a = mdat_i[7:0];
          n.pc = regs_i.pc + 16'd2;
        end
        c8ie_pkg::OP_LDH_C_A: begin
          a1 = c8ie_pkg::acc_wr(c8ie_pkg::IO_PAGE | {8'd0, regs_i.bc[7:0]}, regs_i.a);
        end
        c8ie_pkg::OP_LDH_A_C: begin
          a1 = c8ie_pkg::acc_rd(c8ie_pkg::IO_PAGE | {8'd0, regs_i.bc[7:0]});
          n.a = mdat_i[7:0];
        end
        c8ie_pkg::OP_LD_NN_A: begin
          a1 = c8ie_pkg::acc_wr(nn, regs_i.a);
          n.pc = regs_i.pc + 16'd3;
        end
        c8ie_pkg::OP_LD_A_NN: begin
          a1 = c8ie_pkg::acc_rd(nn);
          n.a = mdat_i[7:0];
          n.pc = regs_i.pc + 16'd3;
        end
        c8ie_pkg::OP_ADD_SP: begin
          n.f = {2'b00, h5[4], c9[8]};
          n.sp = regs_i.sp + sext;
          n.pc = regs_i.pc + 16'd2;
        end
        c8ie_pkg::OP_JP_HL: n.pc = regs_i.hl;
        c8ie_pkg::OP_DI: n.ime = 1'b0;
        c8ie_pkg::OP_EI: n.ime = 1'b1;
        default: n.pc = pc1;
      endcase
    end
  end

  always_comb begin
    regs_o = n;
    taken_o = taken;
    acc1_o = a1;
    acc2_o = a2;
    if (a2.wr) begin
      store_o = '{valid: 1'b1, addr: a2.addr, data: a2.data};
    end else if (a1.wr) begin
      store_o = '{valid: 1'b1, addr: a1.addr, data: a1.data};
    end else begin
      store_o = '0;
    end
  end

endmodule

[rtl/cpu8_instruction_execute.sv]
// Top level: input beat buffer, sequencer, byte memory and result register.
// An instruction leaves the buffer in ST_IDLE and commits from ST_MEM1, or ST_MEM2 for POP and
// any RET that returns, once the output can take it; the next one is taken only after that
// commit, as all accesses share the one memory port. Reset clears the architectural registers;
// the memory is then zeroed, one byte a cycle, during which no input beat is taken.
// Depends on c8ie_pkg and c8ie_exec.
module cpu8_instruction_execute #(
  parameter int MEM_ADDR_BITS = c8ie_pkg::MEM_ADDR_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,  // op[7:0], imm_low[15:8], imm_high[23:16]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [119:0] m_axis_tdata   // next_pc, acc_out, flags_out, pair_bc, pair_de,
                                      // pair_hl, stack_ptr, irq_enable, cond_taken,
                                      // store_valid, store_addr, store_data, zero pad
);

  localparam int MemDepth = 2 ** MEM_ADDR_BITS;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_MEM1, ST_MEM2} state_e;

  state_e                   state_q;
  logic [MEM_ADDR_BITS-1:0] clr_q;
  logic                     ib_valid_q;
  logic [23:0]              ib_data_q;
  logic [23:0]              ex_data_q;
  c8ie_pkg::regs_t          regs_q;
  logic                     out_valid_q;
  logic [119:0]             out_q;
  logic [7:0]               rdata_q;
  logic [7:0]               lo_q;
  logic [7:0]               mem_q [MemDepth];

  logic                     take;
  logic                     commit;
  logic                     s_beat;
  logic [23:0]              ex_in;
  logic [15:0]              mdat;
  c8ie_pkg::regs_t          regs_n;
  logic                     taken;
  c8ie_pkg::acc_t           acc1;
  c8ie_pkg::acc_t           acc2;
  c8ie_pkg::store_t         store;
  logic                     mem_we;
  logic                     mem_re;
  logic [MEM_ADDR_BITS-1:0] mem_addr;
  logic [7:0]               mem_wdata;

  assign take = (state_q == ST_IDLE) && ib_valid_q;
  assign s_axis_tready = (state_q != ST_CLEAR) && (!ib_valid_q || take);
  assign s_beat = s_axis_tvalid && s_axis_tready;
  assign commit = (((state_q == ST_MEM1) && !acc2.rd) || (state_q == ST_MEM2)) &&
                  (!out_valid_q || m_axis_tready);
  assign ex_in = (state_q == ST_IDLE) ? ib_data_q : ex_data_q;
  assign mdat = (state_q == ST_MEM2) ? {rdata_q, lo_q} : {8'h00, rdata_q};
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_q;

  c8ie_exec u_exec (
    .op_i    (ex_in[7:0]),
    .lo_i    (ex_in[15:8]),
    .hi_i    (ex_in[23:16]),
    .regs_i  (regs_q),
    .mdat_i  (mdat),
    .regs_o  (regs_n),
    .taken_o (taken),
    .acc1_o  (acc1),
    .acc2_o  (acc2),
    .store_o (store)
  );

  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_addr = clr_q;
    mem_wdata = 8'h00;
    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        mem_we = take && acc1.wr;
        mem_re = take && acc1.rd;
        mem_addr = acc1.addr[MEM_ADDR_BITS-1:0];
        mem_wdata = acc1.data;
      end
      ST_MEM1: begin
        mem_we = acc2.wr;
        mem_re = acc2.rd;
        mem_addr = acc2.addr[MEM_ADDR_BITS-1:0];
        mem_wdata = acc2.data;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0;
      ib_valid_q <= 1'b0;
      regs_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_beat) begin
        ib_valid_q <= 1'b1;
        ib_data_q <= s_axis_tdata;
      end else if (take) begin
        ib_valid_q <= 1'b0;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
        regs_q <= regs_n;
        out_q <= {1'b0, store.data, store.addr, store.valid, taken, regs_n.ime,
                  regs_n.sp, regs_n.hl, regs_n.de, regs_n.bc, regs_n.f, regs_n.a,
                  regs_n.pc};
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (take) begin
            ex_data_q <= ib_data_q;
            state_q <= ST_MEM1;
          end
        end
        ST_MEM1: begin
          lo_q <= rdata_q;
          if (acc2.rd) begin
            state_q <= ST_MEM2;
          end else if (commit) begin
            state_q <= ST_IDLE;
          end
        end
        ST_MEM2: begin
          if (commit) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready)
    else $error("input beat offered ready during memory clearing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> m_axis_tvalid)
    else $error("committed instruction did not produce a result beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MEM2) |-> ($past(state_q) == ST_MEM1 || $past(state_q) == ST_MEM2))
    else $error("second read phase entered without first phase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (state_q == ST_MEM1))
    else $error("buffered instruction was not started");

endmodule

[dv/tb_cpu8_instruction_execute.sv]
// Self-checking testbench for cpu8_instruction_execute: drives instruction beats, predicts
// the register file, flags and memory in a local model and compares every result beat.
// Depends on c8ie_pkg and the cpu8_instruction_execute RTL.
module tb_cpu8_instruction_execute;
  import c8ie_pkg::*;

  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  a;
    logic [3:0]  f;
    logic [15:0] bc;
    logic [15:0] de;
    logic [15:0] hl;
    logic [15:0] sp;
    logic        ime;
    logic        taken;
    logic        st_v;
    logic [15:0] st_a;
    logic [7:0]  st_d;
  } exec_res_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [23:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;

  cpu8_instruction_execute dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic [23:0] instr_q[$];
  exec_res_t   result_q[$];
  int          errors = 0;
  bit          stim_done = 1'b0;

  // Predictor state.
  logic [7:0]  m_a;
  logic [3:0]  m_f;
  logic [15:0] m_rp[4];
  logic [15:0] m_pc;
  logic        m_ime;
  logic [7:0]  m_mem[65536];
  logic        s_v;
  logic [15:0] s_a;
  logic [7:0]  s_d;

  function automatic logic [7:0] rd8(logic [15:0] ad);
    return m_mem[ad];
  endfunction

  function automatic void wr8(logic [15:0] ad, logic [7:0] d);
    m_mem[ad] = d;
    s_v = 1'b1;
    s_a = ad;
    s_d = d;
  endfunction

  function automatic logic [7:0] reg_rd(logic [2:0] r);
    case (r)
      REG_B: return m_rp[0][15:8];
      REG_C: return m_rp[0][7:0];
      REG_D: return m_rp[1][15:8];
      REG_E: return m_rp[1][7:0];
      REG_H: return m_rp[2][15:8];
      REG_L: return m_rp[2][7:0];
      REG_M: return rd8(m_rp[2]);
      default: return m_a;
    endcase
  endfunction

  function automatic void reg_wr(logic [2:0] r, logic [7:0] v);
    case (r)
      REG_B: m_rp[0][15:8] = v;
      REG_C: m_rp[0][7:0] = v;
      REG_D: m_rp[1][15:8] = v;
      REG_E: m_rp[1][7:0] = v;
      REG_H: m_rp[2][15:8] = v;
      REG_L: m_rp[2][7:0] = v;
      REG_M: wr8(m_rp[2], v);
      default: m_a = v;
    endcase
  endfunction

  function automatic void alu_op(logic [2:0] sel, logic [7:0] v);
    logic [8:0] r;
    logic       c;
    c = ((sel == ALU_ADC) || (sel == ALU_SBC)) ? m_f[0] : 1'b0;
    case (sel)
      ALU_ADD, ALU_ADC: begin
        r = m_a + v + c;
        m_f[1] = ({1'b0, m_a[3:0]} + v[3:0] + c) > 5'd15;
        m_f[0] = r[8];
        m_f[2] = 1'b0;
      end
      ALU_SUB, ALU_SBC, ALU_CP: begin
        r = {1'b0, m_a} - v - c;
        m_f[1] = {1'b0, m_a[3:0]} < ({1'b0, v[3:0]} + c);
        m_f[0] = {1'b0, m_a} < ({1'b0, v} + c);
        m_f[2] = 1'b1;
      end
      ALU_AND: begin r = m_a & v; m_f = 4'b0010; end
      ALU_XOR: begin r = m_a ^ v; m_f = 4'b0000; end
      default: begin r = m_a | v; m_f = 4'b0000; end
    endcase
    m_f[3] = (r[7:0] == 8'd0);
    if (sel != ALU_CP) m_a = r[7:0];
  endfunction

  function automatic logic cc_ok(logic [1:0] cc);
    logic b;
    b = cc[1] ? m_f[0] : m_f[3];
    return cc[0] ? b : !b;
  endfunction

  function automatic void push_word(logic [15:0] v);
    m_rp[3] = m_rp[3] - 16'd1;
    wr8(m_rp[3], v[15:8]);
    m_rp[3] = m_rp[3] - 16'd1;
    wr8(m_rp[3], v[7:0]);
  endfunction

  function automatic logic [15:0] pop_word();
    logic [15:0] v;
    v[7:0] = rd8(m_rp[3]);
    m_rp[3] = m_rp[3] + 16'd1;
    v[15:8] = rd8(m_rp[3]);
    m_rp[3] = m_rp[3] + 16'd1;
    return v;
  endfunction

  function automatic exec_res_t execute(logic [23:0] item);
    logic [7:0]  op, lo, v;
    logic [15:0] nn, pc, nxt, ofs;
    logic [2:0]  r;
    logic [1:0]  p;
    logic        tk, c;
    logic [16:0] s17;
    logic [8:0]  a9;
    exec_res_t   res;
    op = item[7:0];
    lo = item[15:8];
    nn = item[23:8];
    pc = m_pc;
    nxt = pc + 16'd1;
    r = op[5:3];
    p = op[5:4];
    tk = 1'b0;
    ofs = {{8{lo[7]}}, lo};
    s_v = 1'b0; s_a = '0; s_d = '0;
    if (op >= 8'h40 && op < 8'h80) begin
      if (op != OP_HALT) reg_wr(r, reg_rd(op[2:0]));
    end else if (op >= 8'h80 && op < 8'hC0) begin
      alu_op(r, reg_rd(op[2:0]));
    end else if ((op & 8'hC7) == 8'h04) begin
      v = reg_rd(r);
      m_f[1] = (v[3:0] == 4'hF);
      m_f[3] = (v == 8'hFF);
      m_f[2] = 1'b0;
      reg_wr(r, v + 8'd1);
    end else if ((op & 8'hC7) == 8'h05) begin
      v = reg_rd(r);
      m_f[1] = (v[3:0] == 4'h0);
      m_f[3] = (v == 8'h01);
      m_f[2] = 1'b1;
      reg_wr(r, v - 8'd1);
    end else if ((op & 8'hC7) == 8'h06) begin
      reg_wr(r, lo); nxt = pc + 16'd2;
    end else if ((op & 8'hCF) == 8'h01) begin
      m_rp[p] = nn; nxt = pc + 16'd3;
    end else if ((op & 8'hCF) == 8'h03) begin
      m_rp[p] = m_rp[p] + 16'd1;
    end else if ((op & 8'hCF) == 8'h0B) begin
      m_rp[p] = m_rp[p] - 16'd1;
    end else if ((op & 8'hCF) == 8'h09) begin
      s17 = m_rp[2] + m_rp[p];
      m_f[1] = ({1'b0, m_rp[2][11:0]} + m_rp[p][11:0]) > 13'hFFF;
      m_f[0] = s17[16];
      m_f[2] = 1'b0;
      m_rp[2] = s17[15:0];
    end else if ((op & 8'hE7) == 8'h20) begin
      nxt = pc + 16'd2;
      if (cc_ok(r[1:0])) begin nxt = nxt + ofs; tk = 1'b1; end
    end else if ((op & 8'hE7) == 8'hC0) begin
      if (cc_ok(r[1:0])) begin nxt = pop_word(); tk = 1'b1; end
    end else if ((op & 8'hE7) == 8'hC2) begin
      nxt = pc + 16'd3;
      if (cc_ok(r[1:0])) begin nxt = nn; tk = 1'b1; end
    end else if ((op & 8'hE7) == 8'hC4) begin
      nxt = pc + 16'd3;
      if (cc_ok(r[1:0])) begin push_word(nxt); nxt = nn; tk = 1'b1; end
    end else if ((op & 8'hCF) == 8'hC1) begin
      nn = pop_word();
      if (p == PAIR_SP) begin m_a = nn[15:8]; m_f = nn[7:4]; end
      else m_rp[p] = nn;
    end else if ((op & 8'hCF) == 8'hC5) begin
      push_word(p == PAIR_SP ? {m_a, m_f, 4'h0} : m_rp[p]);
    end else if ((op & 8'hC7) == 8'hC6) begin
      alu_op(r, lo); nxt = pc + 16'd2;
    end else if ((op & 8'hC7) == 8'hC7) begin
      push_word(pc + 16'd1); nxt = {8'h00, op & 8'h38};
    end else begin
      c = m_f[0];
      case (op)
        OP_LD_BC_A: wr8(m_rp[0], m_a);
        OP_LD_DE_A: wr8(m_rp[1], m_a);
        OP_LDI_HL_A: begin wr8(m_rp[2], m_a); m_rp[2] = m_rp[2] + 16'd1; end
        OP_LDD_HL_A: begin wr8(m_rp[2], m_a); m_rp[2] = m_rp[2] - 16'd1; end
        OP_LD_A_BC: m_a = rd8(m_rp[0]);
        OP_LD_A_DE: m_a = rd8(m_rp[1]);
        OP_LDI_A_HL: begin m_a = rd8(m_rp[2]); m_rp[2] = m_rp[2] + 16'd1; end
        OP_RLCA: begin m_f = {3'b000, m_a[7]}; m_a = {m_a[6:0], m_a[7]}; end
        OP_RRCA: begin m_f = {3'b000, m_a[0]}; m_a = {m_a[0], m_a[7:1]}; end
        OP_RLA: begin m_f = {3'b000, m_a[7]}; m_a = {m_a[6:0], c}; end
        OP_RRA: begin m_f = {3'b000, m_a[0]}; m_a = {c, m_a[7:1]}; end
        OP_LD_NN_SP: begin
          wr8(nn, m_rp[3][7:0]);
          wr8(nn + 16'd1, m_rp[3][15:8]);
          nxt = pc + 16'd3;
        end
        OP_STOP: nxt = pc + 16'd2;
        OP_JR: nxt = pc + 16'd2 + ofs;
        OP_DAA: begin
          a9 = {1'b0, m_a};
          if (!m_f[2]) begin
            if (c || m_a > 8'h99) begin a9 = a9 + 9'h60; c = 1'b1; end
            if (m_f[1] || a9[3:0] > 4'h9) a9 = a9 + 9'h06;
          end else begin
            if (c) a9 = a9 - 9'h60;
            if (m_f[1]) a9 = a9 - 9'h06;
          end
          m_a = a9[7:0];
          m_f[0] = c;
          m_f[1] = 1'b0;
          m_f[3] = (m_a == 8'd0);
        end
        OP_CPL: begin m_a = ~m_a; m_f[2] = 1'b1; m_f[1] = 1'b1; end
        OP_SCF: begin m_f[2] = 1'b0; m_f[1] = 1'b0; m_f[0] = 1'b1; end
        OP_CCF: begin m_f[2] = 1'b0; m_f[1] = 1'b0; m_f[0] = !c; end
        OP_JP: nxt = nn;
        OP_RET: nxt = pop_word();
        OP_CALL: begin push_word(pc + 16'd3); nxt = nn; end
        OP_LDH_N_A: begin wr8(IO_PAGE + lo, m_a); nxt = pc + 16'd2; end
        OP_LDH_A_N: begin m_a = rd8(IO_PAGE + lo); nxt = pc + 16'd2; end
        OP_LDH_C_A: wr8(IO_PAGE + m_rp[0][7:0], m_a);
        OP_LDH_A_C: m_a = rd8(IO_PAGE + m_rp[0][7:0]);
        OP_LD_NN_A: begin wr8(nn, m_a); nxt = pc + 16'd3; end
        OP_LD_A_NN: begin m_a = rd8(nn); nxt = pc + 16'd3; end
        OP_ADD_SP: begin
          m_f = 4'b0000;
          m_f[1] = ({1'b0, m_rp[3][3:0]} + lo[3:0]) > 5'd15;
          m_f[0] = ({1'b0, m_rp[3][7:0]} + lo) > 9'hFF;
          m_rp[3] = m_rp[3] + ofs;
          nxt = pc + 16'd2;
        end
        OP_JP_HL: nxt = m_rp[2];
        OP_DI: m_ime = 1'b0;
        OP_EI: m_ime = 1'b1;
        default: ;
      endcase
    end
    m_pc = nxt;
    res = '{m_pc, m_a, m_f, m_rp[0], m_rp[1], m_rp[2], m_rp[3], m_ime, tk, s_v, s_a, s_d};
    return res;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (instr_q.size() > 0) begin
          s_axis_tdata <= instr_q[0];
          result_q.push_back(execute(instr_q.pop_front()));
          s_axis_tvalid <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, with one long hold-off early on and a stall-free stretch later.
  int beats_seen = 0;
  int hold_cnt = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (beats_seen == 40 && hold_cnt < 300) begin
        hold_cnt <= hold_cnt + 1;
        m_axis_tready <= 1'b0;
      end else if (beats_seen > 300 && beats_seen < 500) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Monitor and checker.
  always @(posedge clk_i) begin
    exec_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      beats_seen <= beats_seen + 1;
      got.pc = m_axis_tdata[15:0];
      got.a = m_axis_tdata[23:16];
      got.f = m_axis_tdata[27:24];
      got.bc = m_axis_tdata[43:28];
      got.de = m_axis_tdata[59:44];
      got.hl = m_axis_tdata[75:60];
      got.sp = m_axis_tdata[91:76];
      got.ime = m_axis_tdata[92];
      got.taken = m_axis_tdata[93];
      got.st_v = m_axis_tdata[94];
      got.st_a = m_axis_tdata[110:95];
      got.st_d = m_axis_tdata[118:111];
      if (result_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = result_q.pop_front();
        if (got.pc !== want.pc) begin
          $display("%0t: next_pc expected %h actual %h", $time, want.pc, got.pc); errors++;
        end
        if (got.a !== want.a) begin
          $display("%0t: acc_out expected %h actual %h", $time, want.a, got.a); errors++;
        end
        if (got.f !== want.f) begin
          $display("%0t: flags_out expected %h actual %h", $time, want.f, got.f); errors++;
        end
        if (got.bc !== want.bc) begin
          $display("%0t: pair_bc expected %h actual %h", $time, want.bc, got.bc); errors++;
        end
        if (got.de !== want.de) begin
          $display("%0t: pair_de expected %h actual %h", $time, want.de, got.de); errors++;
        end
        if (got.hl !== want.hl) begin
          $display("%0t: pair_hl expected %h actual %h", $time, want.hl, got.hl); errors++;
        end
        if (got.sp !== want.sp) begin
          $display("%0t: stack_ptr expected %h actual %h", $time, want.sp, got.sp); errors++;
        end
        if (got.ime !== want.ime) begin
          $display("%0t: irq_enable expected %h actual %h", $time, want.ime, got.ime);
          errors++;
        end
        if (got.taken !== want.taken) begin
          $display("%0t: cond_taken expected %h actual %h", $time, want.taken, got.taken);
          errors++;
        end
        if (got.st_v !== want.st_v) begin
          $display("%0t: store_valid expected %h actual %h", $time, want.st_v, got.st_v);
          errors++;
        end
        if (got.st_a !== want.st_a) begin
          $display("%0t: store_addr expected %h actual %h", $time, want.st_a, got.st_a);
          errors++;
        end
        if (got.st_d !== want.st_d) begin
          $display("%0t: store_data expected %h actual %h", $time, want.st_d, got.st_d);
          errors++;
        end
      end
    end
  end

  function automatic logic [23:0] pick_instr();
    logic [7:0] op;
    logic [15:0] nn;
    op = $urandom_range(0, 255);
    nn = $urandom;
    case ($urandom_range(0, 9))
      0: nn = {8'hFF, nn[7:0]};
      1: nn = {8'hC0 | nn[13:8], nn[7:0]};
      default: ;
    endcase
    return {nn, op};
  endfunction

  initial begin
    logic [7:0] dir_ops[$];
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Pointers into a live region, then stores, loads, stack and branches.
    dir_ops = '{8'h31, 8'h21, 8'h01, 8'h3E, 8'h77, 8'h34, 8'h35, 8'h27, 8'h2F, 8'hC5,
                8'hF5, 8'hF1, 8'hC1, 8'h08, 8'hCD, 8'hC9, 8'hFF, 8'hE8, 8'h8F, 8'h9F,
                8'h1F, 8'h76, 8'h10, 8'hCB, 8'hFB};
    foreach (dir_ops[i]) begin
      case (dir_ops[i])
        8'h31: instr_q.push_back({16'hFFFE, dir_ops[i]});
        8'h21: instr_q.push_back({16'hC000, dir_ops[i]});
        8'h01: instr_q.push_back({16'hFF80, dir_ops[i]});
        8'h3E: instr_q.push_back({16'h00FF, dir_ops[i]});
        8'h08: instr_q.push_back({16'hFFFF, dir_ops[i]});
        8'hE8: instr_q.push_back({16'h0080, dir_ops[i]});
        default: instr_q.push_back({16'h7F01, dir_ops[i]});
      endcase
    end
    repeat (1250) begin
      instr_q.push_back(pick_instr());
      // Keep the stack and HL in RAM now and then so pops read stored data.
      if ($urandom_range(0, 40) == 0) instr_q.push_back({8'hD0, 8'h00, 8'h31});
      if ($urandom_range(0, 40) == 0) instr_q.push_back({8'hC1, 8'h00, 8'h21});
    end
    stim_done = 1'b1;
  end

  initial begin
    m_a = '0; m_f = '0; m_pc = '0; m_ime = 1'b0;
    foreach (m_rp[i]) m_rp[i] = '0;
    foreach (m_mem[i]) m_mem[i] = '0;
    wait (stim_done && instr_q.size() == 0 && !s_axis_tvalid && result_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #600000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[files.f]
rtl/c8ie_pkg.sv
rtl/c8ie_exec.sv
rtl/cpu8_instruction_execute.sv
dv/tb_cpu8_instruction_execute.sv
